@@ rtl/lsd_radix_sort_decimal_core_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef LSD_RADIX_SORT_DECIMAL_CORE_DEFINES_SVH
`define LSD_RADIX_SORT_DECIMAL_CORE_DEFINES_SVH

// Assert that ante implies cons in the same cycle.
`define LRSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that ante implies cons in the next cycle.
`define LRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lrsd_pkg.sv @@
package lrsd_pkg;

  localparam int unsigned MaxKeysDefault = 64;
  localparam int unsigned Radix = 10;
  localparam int unsigned KeyW = 32;
  localparam int unsigned PayW = 32;
  localparam int unsigned DigW = 4;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS_CHECK,
    ST_CLEAR,
    ST_COUNT_RD,
    ST_COUNT,
    ST_PREFIX,
    ST_SCAT_RD,
    ST_SCAT,
    ST_COPY_RD,
    ST_COPY,
    ST_OUT_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
    logic            last;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0] sorted_key;
    logic [PayW-1:0] sorted_payload;
    logic            final_res;
  } out_item_t;

endpackage

@@ rtl/lrsd_stream_if.sv @@
interface lrsd_stream_if #(
  parameter int unsigned Width = 65
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lrsd_ram.sv @@
module lrsd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/lrsd_digit.sv @@
module lrsd_digit (
  input  logic                       clk,
  input  logic                       start,
  input  logic [lrsd_pkg::KeyW-1:0]  key,
  input  logic [3:0]                 shift_cnt,
  output logic                       done,
  output logic [lrsd_pkg::DigW-1:0]  digit
);
  logic [lrsd_pkg::KeyW-1:0] val_r, val_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic [lrsd_pkg::KeyW+3:0] prod;
  logic [lrsd_pkg::KeyW-1:0] quo;
  logic [lrsd_pkg::KeyW-1:0] rem;

  // Divide by ten with an exact reciprocal multiplication.
  assign prod = 36'((64'(val_r) * 64'hCCCC_CCCD) >> 35);
  assign quo = prod[lrsd_pkg::KeyW-1:0];
  assign rem = val_r - 32'(quo * 32'd10);
  assign done = busy_r && (cnt_r == 4'd0);
  assign digit = rem[lrsd_pkg::DigW-1:0];

  always_comb begin
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      val_nxt = key;
      cnt_nxt = shift_cnt;
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r != 4'd0) begin
      val_nxt = quo;
      cnt_nxt = cnt_r - 4'd1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    cnt_r <= cnt_nxt;
    busy_r <= busy_nxt;
  end
endmodule

@@ rtl/lsd_radix_sort_decimal_core.sv @@
// Loads up to MaxKeys items at one per cycle (key, payload, last); an item with
// last set, or the one that fills the store, starts a decimal LSD radix sort.
// Each pass clears ten counters, counts digits with the shared divide-by-ten
// unit, takes a nine-step prefix sum, scatters from the back, then copies
// scratch back to the store; the store RAMs have one read port, so each item
// of a copy or emit takes a read state before its COPY or OUT state.
// Passes run while the largest key still has a nonzero digit (at most ten).
// Input ready is low from the batch end until its last sorted item is taken.
`include "lsd_radix_sort_decimal_core_defines.svh"
module lsd_radix_sort_decimal_core #(
  parameter int unsigned MaxKeys = lrsd_pkg::MaxKeysDefault
) (
  input logic clk,
  input logic rst_n,
  lrsd_stream_if.sink   in_s,
  lrsd_stream_if.source out_s
);
  localparam int unsigned AW = $clog2(MaxKeys);
  localparam int unsigned CW = ($clog2(MaxKeys + 1) > lrsd_pkg::DigW) ?
                               $clog2(MaxKeys + 1) : lrsd_pkg::DigW;

  lrsd_pkg::state_t state_r, state_nxt;
  lrsd_pkg::in_item_t in_item;
  lrsd_pkg::out_item_t out_item;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [lrsd_pkg::KeyW-1:0] largest_r, largest_nxt;
  logic [lrsd_pkg::KeyW-1:0] lim_r, lim_nxt;
  logic [3:0] pass_r, pass_nxt;
  logic [CW-1:0] dc_r [lrsd_pkg::Radix];
  logic [CW-1:0] dc_nxt [lrsd_pkg::Radix];
  logic ovalid_r, ovalid_nxt;
  logic ofinal_r, ofinal_nxt;
  logic dstart;
  logic ddone;
  logic [lrsd_pkg::DigW-1:0] dig;
  logic [lrsd_pkg::KeyW+3:0] lim_div;
  logic [lrsd_pkg::DigW-1:0] pidx;

  logic st_we, sc_we;
  logic [AW-1:0] st_wa, st_ra, sc_wa, sc_ra;
  logic [lrsd_pkg::KeyW-1:0] st_wk, st_rk, sc_wk, sc_rk;
  logic [lrsd_pkg::PayW-1:0] st_wp, st_rp, sc_wp, sc_rp;
  logic in_acc;
  logic batch_end;

  assign in_item = in_s.data;
  assign in_s.ready = (state_r == lrsd_pkg::ST_LOAD);
  assign in_acc = in_s.valid && in_s.ready;
  assign batch_end = in_item.last || (cnt_r == CW'(MaxKeys - 1));
  assign out_item.sorted_key = st_rk;
  assign out_item.sorted_payload = st_rp;
  assign out_item.final_res = ofinal_r;
  assign out_s.data = out_item;
  assign out_s.valid = ovalid_r;
  assign lim_div = 36'((64'(lim_r) * 64'hCCCC_CCCD) >> 35);
  assign pidx = idx_r[lrsd_pkg::DigW-1:0];

  lrsd_ram #(.Width(lrsd_pkg::KeyW), .Depth(MaxKeys)) u_st_key (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wk), .raddr(st_ra), .rdata(st_rk));
  lrsd_ram #(.Width(lrsd_pkg::PayW), .Depth(MaxKeys)) u_st_pay (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wp), .raddr(st_ra), .rdata(st_rp));
  lrsd_ram #(.Width(lrsd_pkg::KeyW), .Depth(MaxKeys)) u_sc_key (
    .clk, .we(sc_we), .waddr(sc_wa), .wdata(sc_wk), .raddr(sc_ra), .rdata(sc_rk));
  lrsd_ram #(.Width(lrsd_pkg::PayW), .Depth(MaxKeys)) u_sc_pay (
    .clk, .we(sc_we), .waddr(sc_wa), .wdata(sc_wp), .raddr(sc_ra), .rdata(sc_rp));

  lrsd_digit u_digit (
    .clk, .start(dstart), .key(st_rk), .shift_cnt(pass_r), .done(ddone), .digit(dig));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrsd_pkg::ST_LOAD: if (in_acc && batch_end) state_nxt = lrsd_pkg::ST_PASS_CHECK;
      lrsd_pkg::ST_PASS_CHECK: begin
        state_nxt = (lim_r != '0) ? lrsd_pkg::ST_CLEAR : lrsd_pkg::ST_OUT_RD;
      end
      lrsd_pkg::ST_CLEAR: state_nxt = lrsd_pkg::ST_COUNT_RD;
      lrsd_pkg::ST_COUNT_RD: state_nxt = lrsd_pkg::ST_COUNT;
      lrsd_pkg::ST_COUNT: begin
        if (ddone) begin
          state_nxt = (idx_r + CW'(1) == cnt_r) ? lrsd_pkg::ST_PREFIX : lrsd_pkg::ST_COUNT_RD;
        end
      end
      lrsd_pkg::ST_PREFIX: if (idx_r == CW'(lrsd_pkg::Radix - 1)) state_nxt = lrsd_pkg::ST_SCAT_RD;
      lrsd_pkg::ST_SCAT_RD: state_nxt = lrsd_pkg::ST_SCAT;
      lrsd_pkg::ST_SCAT: begin
        if (ddone) begin
          state_nxt = (idx_r == CW'(1)) ? lrsd_pkg::ST_COPY_RD : lrsd_pkg::ST_SCAT_RD;
        end
      end
      lrsd_pkg::ST_COPY_RD: state_nxt = lrsd_pkg::ST_COPY;
      lrsd_pkg::ST_COPY: begin
        state_nxt = (idx_r + CW'(1) == cnt_r) ? lrsd_pkg::ST_PASS_CHECK : lrsd_pkg::ST_COPY_RD;
      end
      lrsd_pkg::ST_OUT_RD: state_nxt = lrsd_pkg::ST_OUT;
      lrsd_pkg::ST_OUT: begin
        if (out_s.ready) begin
          state_nxt = ofinal_r ? lrsd_pkg::ST_LOAD : lrsd_pkg::ST_OUT_RD;
        end
      end
      default: state_nxt = lrsd_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    largest_nxt = largest_r;
    lim_nxt = lim_r;
    pass_nxt = pass_r;
    dc_nxt = dc_r;
    ovalid_nxt = 1'b0;
    ofinal_nxt = ofinal_r;
    dstart = 1'b0;
    st_we = 1'b0;
    sc_we = 1'b0;
    st_wa = idx_r[AW-1:0];
    st_ra = idx_r[AW-1:0];
    sc_wa = '0;
    sc_ra = idx_r[AW-1:0];
    st_wk = in_item.key;
    st_wp = in_item.payload;
    sc_wk = st_rk;
    sc_wp = st_rp;
    unique case (state_r)
      lrsd_pkg::ST_LOAD: begin
        st_wa = cnt_r[AW-1:0];
        if (in_acc) begin
          st_we = 1'b1;
          if (cnt_r == '0 || in_item.key > largest_r) largest_nxt = in_item.key;
          cnt_nxt = cnt_r + CW'(1);
          if (batch_end) begin
            lim_nxt = (cnt_r == '0 || in_item.key > largest_r) ? in_item.key : largest_r;
            pass_nxt = '0;
          end
        end
      end
      lrsd_pkg::ST_PASS_CHECK: idx_nxt = '0;
      lrsd_pkg::ST_CLEAR: begin
        for (int i = 0; i < lrsd_pkg::Radix; i++) dc_nxt[i] = '0;
        idx_nxt = '0;
      end
      lrsd_pkg::ST_COUNT_RD: dstart = 1'b0;
      lrsd_pkg::ST_COUNT: begin
        if (ddone) begin
          st_ra = idx_r[AW-1:0] + AW'(1);
          dc_nxt[dig] = dc_r[dig] + CW'(1);
          idx_nxt = idx_r + CW'(1);
          if (idx_r + CW'(1) == cnt_r) idx_nxt = CW'(1);
        end
      end
      lrsd_pkg::ST_PREFIX: begin
        dc_nxt[pidx] = dc_r[pidx] + dc_r[pidx - lrsd_pkg::DigW'(1)];
        idx_nxt = idx_r + CW'(1);
        if (idx_r == CW'(lrsd_pkg::Radix - 1)) begin
          idx_nxt = cnt_r;
          st_ra = cnt_r[AW-1:0] - AW'(1);
        end
      end
      lrsd_pkg::ST_SCAT_RD: st_ra = idx_r[AW-1:0] - AW'(1);
      lrsd_pkg::ST_SCAT: begin
        st_ra = idx_r[AW-1:0] - AW'(1);
        if (ddone) begin
          st_ra = idx_r[AW-1:0] - AW'(2);
          sc_we = 1'b1;
          sc_wa = AW'(dc_r[dig] - CW'(1));
          dc_nxt[dig] = dc_r[dig] - CW'(1);
          idx_nxt = idx_r - CW'(1);
          if (idx_r == CW'(1)) idx_nxt = '0;
        end
      end
      lrsd_pkg::ST_COPY_RD: sc_ra = idx_r[AW-1:0];
      lrsd_pkg::ST_COPY: begin
        st_we = 1'b1;
        st_wk = sc_rk;
        st_wp = sc_rp;
        idx_nxt = idx_r + CW'(1);
        if (idx_r + CW'(1) == cnt_r) begin
          lim_nxt = lim_div[lrsd_pkg::KeyW-1:0];
          pass_nxt = pass_r + 4'd1;
        end
      end
      lrsd_pkg::ST_OUT_RD: begin
        ovalid_nxt = 1'b1;
        ofinal_nxt = (idx_r + CW'(1) == cnt_r);
      end
      lrsd_pkg::ST_OUT: begin
        ovalid_nxt = !out_s.ready;
        if (out_s.ready) begin
          idx_nxt = idx_r + CW'(1);
          if (ofinal_r) begin
            cnt_nxt = '0;
            largest_nxt = '0;
            idx_nxt = '0;
          end
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
    // The digit unit starts in the cycle after the read so its key is valid.
    if (state_r == lrsd_pkg::ST_COUNT_RD || state_r == lrsd_pkg::ST_SCAT_RD) dstart = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrsd_pkg::ST_LOAD;
      cnt_r <= '0;
      idx_r <= '0;
      largest_r <= '0;
      ovalid_r <= 1'b0;
      ofinal_r <= 1'b0;
      pass_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      largest_r <= largest_nxt;
      ovalid_r <= ovalid_nxt;
      ofinal_r <= ofinal_nxt;
      pass_r <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r <= lim_nxt;
    dc_r <= dc_nxt;
  end

  `LRSD_ASSERT_IMP(a_ready_only_load, clk, rst_n, ovalid_r, !in_s.ready, "ready during emit")
  `LRSD_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, cnt_r <= CW'(MaxKeys), "count overflow")
  `LRSD_ASSERT_NEXT(a_final_clears, clk, rst_n, ovalid_r && out_s.ready && ofinal_r,
    cnt_r == '0, "count not cleared")
endmodule
